/* hw/rtl/bba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Block index width of the request and result fields
  localparam int IDX_W = 10;
  // Number of blocks that a 10-bit index can name
  localparam int IDX_SPAN = 1 << IDX_W;
  // Default store size
  localparam int NUM_BLOCKS_DEF = 1024;
  // Reset value of the first allocatable block register
  localparam logic [IDX_W-1:0] FIRST_ALLOC_RST = IDX_W'(12);

  // Mark memory word: one used bit per block
  localparam int WORD_W = 16;
  localparam int WORD_BITS = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_HOLD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // write one word of the clearing pass
    logic load;      // capture the accepted request
    logic rd;        // read the current mark word
    logic eval;      // evaluate the word read, update marks
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // clearing pass is on its last word
    logic fast;      // incoming request needs no memory access
    logic more;      // allocate must visit another word
  } sts_t;

endpackage

/* hw/rtl/bba_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: operation and block index with valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic              valid;
  logic              ready;
  bba_pkg::op_t      op;
  bba_pkg::idx_t     block_index;

  modport source(output valid, op, block_index, input ready);
  modport sink(input valid, op, block_index, output ready);
endinterface

/* hw/rtl/bba_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_rsp_if
// Result channel: granted block and success flag with valid/ready.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  logic              valid;
  logic              ready;
  bba_pkg::idx_t     granted_block;
  logic              success;

  modport source(output valid, granted_block, success, input ready);
  modport sink(input valid, granted_block, success, output ready);
endinterface

/* hw/rtl/bitmap_block_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a bitmap of used marks.
// ----------------------------------------------------------------------------
// Requests arrive on in_req (op, block_index); each gives exactly one result
// on out_rsp (granted_block, success), in request order. cfg_we/cfg_wdata
// set the lowest block index that allocate may hand out (reset 12).
// Marks live in a memory of 16-bit words, one block per bit, with a
// one-bit "word full" summary per word.
// After reset a clearing pass writes every word, one per cycle; in_req.ready
// stays low until it ends. An accepted request goes from idle to a read and
// an evaluate step on its starting word, then to the hold state, which moves
// the result into the output register and returns to idle. Allocate that
// finds no free block there repeats read and evaluate on each next non-full
// word. Requests that need no memory access (index out of range) go from
// idle straight to hold. The memory read-modify-write loop does one read and
// one evaluate step per word visited.
// One request is in flight at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver stalls it.
// While out_rsp stalls with a result held, a finished request waits.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  bba_pkg::idx_t  cfg_wdata,
  bba_req_if.sink        in_req,
  bba_rsp_if.source      out_rsp
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // Sequencing
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Marks, search and results
  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_req.op),
    .in_block_index    (in_req.block_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_granted_block (out_rsp.granted_block),
    .out_success       (out_rsp.success)
  );

endmodule

/* hw/rtl/bba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: clearing pass, request sequencing and output valid.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output bba_pkg::cmd_t   cmd,
  input  bba_pkg::sts_t   sts
);

  bba_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sts.fast ? bba_pkg::ST_HOLD : bba_pkg::ST_READ;
      end
      bba_pkg::ST_READ: begin
        state_nxt = bba_pkg::ST_EVAL;
      end
      bba_pkg::ST_EVAL: begin
        state_nxt = sts.more ? bba_pkg::ST_READ : bba_pkg::ST_HOLD;
      end
      bba_pkg::ST_HOLD: begin
        if (slot_free) state_nxt = bba_pkg::ST_IDLE;
      end
      default: state_nxt = bba_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      bba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bba_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      bba_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      bba_pkg::ST_HOLD: begin
        cmd.load_out = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output valid: set on load_out, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/bba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Mark memory, word-full summary, first-fit search and result registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  bba_pkg::idx_t   cfg_wdata,
  input  bba_pkg::op_t    in_op,
  input  bba_pkg::idx_t   in_block_index,
  input  bba_pkg::cmd_t   cmd,
  output bba_pkg::sts_t   sts,
  output bba_pkg::idx_t   out_granted_block,
  output logic            out_success
);

  localparam int IDX_W     = bba_pkg::IDX_W;
  localparam int WORD_W    = bba_pkg::WORD_W;
  localparam int WORD_BITS = bba_pkg::WORD_BITS;
  // Only blocks a 10-bit index can name are stored
  localparam int REACH     = (NUM_BLOCKS < bba_pkg::IDX_SPAN) ? NUM_BLOCKS : bba_pkg::IDX_SPAN;
  localparam int NUM_WORDS = (REACH + WORD_W - 1) / WORD_W;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [IDX_W:0] REACH_W = (IDX_W+1)'(REACH);

  // Registers
  bba_pkg::idx_t   fa_r;
  bba_pkg::op_t    op_r;
  bba_pkg::idx_t   blk_r;
  logic [WA-1:0]   waddr_r;
  logic            first_r;
  logic [WA-1:0]   clr_addr_r;
  bba_pkg::word_t  rd_data_r;
  logic [NUM_WORDS-1:0] full_r;
  bba_pkg::idx_t   res_block_r;
  logic            res_ok_r;
  bba_pkg::idx_t   out_block_r;
  logic            out_ok_r;

  bba_pkg::word_t  mem [NUM_WORDS];

  // Combinational
  logic [WA-1:0]   in_word, fa_word, start_word;
  logic            fa_out, blk_out;
  bba_pkg::word_t  bit_oh, lo_mask, cand, cand_oh, new_word, pad_word;
  logic [WORD_BITS-1:0] pos;
  logic            hit, upd, more_avail;
  logic [NUM_WORDS-1:0] wcand;
  logic [WA-1:0]   next_word;
  logic [WA-1:0]   mem_wa;
  bba_pkg::word_t  mem_wd;
  logic            mem_we;
  bba_pkg::idx_t   eval_block;
  logic            eval_ok;

  // Request decode and range checks
  assign in_word    = WA'(in_block_index >> WORD_BITS);
  assign fa_word    = WA'(fa_r >> WORD_BITS);
  assign start_word = (in_op == bba_pkg::OP_ALLOC) ? fa_word : in_word;
  assign fa_out     = {1'b0, fa_r} >= REACH_W;
  assign blk_out    = {1'b0, in_block_index} >= REACH_W;

  assign sts.fast     = (in_op == bba_pkg::OP_ALLOC) ? fa_out : blk_out;
  assign sts.clr_last = (clr_addr_r == WA'(NUM_WORDS - 1));

  // Lowest free bit of the word read, at or above the start offset
  assign bit_oh  = bba_pkg::word_t'(1) << blk_r[WORD_BITS-1:0];
  assign lo_mask = first_r ? ({WORD_W{1'b1}} << fa_r[WORD_BITS-1:0]) : {WORD_W{1'b1}};
  assign cand    = ~rd_data_r & lo_mask;
  assign cand_oh = cand & (~cand + bba_pkg::word_t'(1));
  assign hit     = |cand;

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (cand_oh[b]) pos = pos | WORD_BITS'(b);
    end
  end

  // Next word above the current one that is not full
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      wcand[i] = !full_r[i] && (WA'(i) > waddr_r);
    end
  end

  always_comb begin
    next_word = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (wcand[i]) next_word = WA'(i);
    end
  end

  assign more_avail = |wcand;
  assign sts.more   = (op_r == bba_pkg::OP_ALLOC) && !hit && more_avail;

  // Word update and result of the evaluated request
  always_comb begin
    new_word   = rd_data_r;
    upd        = 1'b0;
    eval_block = blk_r;
    eval_ok    = 1'b1;
    case (op_r)
      bba_pkg::OP_ALLOC: begin
        new_word   = rd_data_r | cand_oh;
        upd        = hit;
        eval_block = hit ? IDX_W'({waddr_r, pos}) : '0;
        eval_ok    = hit;
      end
      bba_pkg::OP_FREE: begin
        new_word = rd_data_r & ~bit_oh;
        upd      = 1'b1;
      end
      bba_pkg::OP_MARK: begin
        new_word = rd_data_r | bit_oh;
        upd      = 1'b1;
      end
      default: begin
        eval_ok = !rd_data_r[blk_r[WORD_BITS-1:0]];
      end
    endcase
  end

  // Clearing pass word: blocks past the store read as used
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pad_word[b] = ((int'(clr_addr_r) * WORD_W + b) >= REACH);
    end
  end

  assign mem_we = cmd.clr || (cmd.eval && upd);
  assign mem_wa = cmd.clr ? clr_addr_r : waddr_r;
  assign mem_wd = cmd.clr ? pad_word : new_word;

  // Mark memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_data_r <= mem[waddr_r];
  end

  // Control state: config, clear counter, full summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r       <= bba_pkg::FIRST_ALLOC_RST;
      clr_addr_r <= '0;
      full_r     <= '0;
    end else begin
      if (cfg_we) fa_r <= cfg_wdata;
      if (cmd.clr) clr_addr_r <= clr_addr_r + WA'(1);
      if (cmd.eval && upd) full_r[waddr_r] <= &new_word;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      blk_r       <= in_block_index;
      waddr_r     <= start_word;
      first_r     <= 1'b1;
      res_block_r <= (in_op == bba_pkg::OP_ALLOC) ? '0 : in_block_index;
      res_ok_r    <= 1'b0;
    end else if (cmd.eval) begin
      if (sts.more) begin
        waddr_r <= next_word;
        first_r <= 1'b0;
      end else begin
        res_block_r <= eval_block;
        res_ok_r    <= eval_ok;
      end
    end
    if (cmd.load_out) begin
      out_block_r <= res_block_r;
      out_ok_r    <= res_ok_r;
    end
  end

  assign out_granted_block = out_block_r;
  assign out_success       = out_ok_r;

endmodule
